/* design/csd_pkg.sv */
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types, constants and helpers for the cubic-spline second
// derivative solver: beat types, store entry types, sequencer states,
// register addresses and Q16.16 arithmetic helpers.
// ----------------------------------------------------------------------------
package csd_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int DATA_W         = 32;
   localparam int PIDX_W         = 6;
   localparam int FRAC_W         = 16;
   localparam int NUM_W          = 56;
   localparam int DEN_W          = 36;
   localparam int CSR_AW         = 4;

   localparam logic signed [DATA_W-1:0] ONE_Q      = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] TWO_Q      = 32'sh0002_0000;
   localparam logic signed [DATA_W-1:0] HALF_Q     = 32'sh0000_8000;
   localparam logic signed [DATA_W-1:0] NEG_HALF_Q = 32'shFFFF_8000;

   localparam logic [CSR_AW-1:0] CSR_NATURAL = 4'h0;
   localparam logic [CSR_AW-1:0] CSR_START   = 4'h4;
   localparam logic [CSR_AW-1:0] CSR_END     = 4'h8;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_value;
      logic signed [DATA_W-1:0] y_value;
      logic                     last_point;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] second_deriv;
      logic [PIDX_W-1:0]        point_index;
      logic                     last_result;
      logic                     error_flag;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
   } pt_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] d;
      logic signed [DATA_W-1:0] r;
   } co_type;

   typedef enum logic [4:0] {
      ST_LOAD, ST_FETCH0, ST_CAP0, ST_FETCH, ST_CAP, ST_SLOPE, ST_FIRST, ST_WR,
      ST_SIG, ST_MULP, ST_P, ST_D, ST_T, ST_MULR, ST_R,
      ST_LAST, ST_MULQ1, ST_QP, ST_MULQ2, ST_DN, ST_WRN,
      ST_BFETCH, ST_BMUL, ST_BSUM, ST_OFETCH, ST_OCAP, ST_OHOLD
   } state_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [DATA_W-1:0] res;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         res = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         res = 32'sh8000_0000;
      end else begin
         res = v[DATA_W-1:0];
      end
      return res;
   endfunction

   // Q16.16 product scaling, truncating toward zero
   function automatic logic signed [47:0] qmul(input logic signed [63:0] prod);
      logic signed [63:0] adj;
      adj = prod + (prod[63] ? 64'sd65535 : 64'sd0);
      return adj[63:16];
   endfunction

endpackage

/* design/csd_div.sv */
// ----------------------------------------------------------------------------
// csd_div
// Shared signed divider: restoring, one quotient bit per cycle, truncating
// toward zero, zero divisor taken as one, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module csd_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [csd_pkg::NUM_W-1:0]  num,
   input  logic signed [csd_pkg::DEN_W-1:0]  den,
   output logic                              done,
   output logic signed [csd_pkg::DATA_W-1:0] quot
);
   import csd_pkg::*;

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_W-1:0]        cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [NUM_W-1:0]         quo_ff, quo_in;
   logic [DEN_W-1:0]         dmag_ff, dmag_in;
   logic signed [DATA_W-1:0] quot_ff, quot_in;

   logic [NUM_W-1:0] num_mag;
   logic [DEN_W-1:0] den_mag;
   logic [DEN_W:0]   rem_sh, rem_dif;
   logic             ge;

   assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign den_mag = (den == '0) ? DEN_W'(1) : (den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den));
   assign rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_dif = rem_sh - {1'b0, dmag_ff};
   assign ge      = (rem_sh >= {1'b0, dmag_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(NUM_W);
         neg_in  = num[NUM_W-1] ^ den[DEN_W-1];
         rem_in  = '0;
         quo_in  = num_mag;
         dmag_in = den_mag;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], ge};
            cnt_in = cnt_ff - STEP_W'(1);
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               quot_in = (quo_ff > NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                             : -quo_ff[DATA_W-1:0];
            end else begin
               quot_in = (quo_ff > NUM_W'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                             : quo_ff[DATA_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* design/cubic_spline_second_derivs.sv */
// ----------------------------------------------------------------------------
// cubic_spline_second_derivs
// Stores points, then solves the tridiagonal spline system (forward sweep,
// back substitution) out of two point/coefficient memories and streams one
// Q16.16 second derivative per point.
//
//   channel | ports               | beat
//   --------+---------------------+------------------------------------
//   req     | req_valid/req_ready | one point x, y, last_point
//   rsp     | rsp_valid/rsp_ready | one derivative, index, last, error
//   csr     | csr_p*              | natural_mode, start_slope, end_slope
//
// Points load at one per cycle. The solve runs on the shared divider: five
// divisions per inner point, issued one at a time. Each result is read from
// the coefficient memory, captured and held until taken before the next is
// fetched. req is held off from the final point until the last result beat
// is taken. Reset is synchronous; the memories need no clearing.
// ----------------------------------------------------------------------------
module cubic_spline_second_derivs #(
   parameter int MAX_POINTS = csd_pkg::MAX_POINTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  csd_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output csd_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [csd_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [csd_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [csd_pkg::DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready
);
   import csd_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             order_err_ff, order_err_in;
   logic             issued_ff, issued_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             natural_ff, natural_in;
   logic signed [DATA_W-1:0] start_slope_ff, start_slope_in;
   logic signed [DATA_W-1:0] end_slope_ff, end_slope_in;

   logic signed [DATA_W-1:0] last_x_ff, last_x_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [DATA_W-1:0] xa_ff, xa_in, xb_ff, xb_in, xc_ff, xc_in;
   logic signed [DATA_W-1:0] yb_ff, yb_in, yc_ff, yc_in;
   logic signed [DATA_W-1:0] sl_ff, sl_in, sr_ff, sr_in, sig_ff, sig_in;
   logic signed [DATA_W-1:0] d_ff, d_in, r_ff, r_in, t_ff, t_in;
   logic signed [DEN_W-1:0]  p_ff, p_in;
   logic signed [63:0]       prod_ff, prod_in;
   rsp_type                  rsp_ff, rsp_in;

   pt_type           pt_mem [MAX_POINTS];
   pt_type           pt_rd_ff;
   logic             pt_we;
   logic [IDX_W-1:0] pt_raddr;
   co_type           co_mem [MAX_POINTS];
   co_type           co_rd_ff;
   co_type           co_wdata;
   logic             co_we;

   logic                     div_start, div_done;
   logic signed [NUM_W-1:0]  div_num;
   logic signed [DEN_W-1:0]  div_den;
   logic signed [DATA_W-1:0] div_quot;

   logic [CNT_W-1:0]  cnt_new;
   logic              err_new;
   logic signed [32:0] dy, dx_cb, dx_ba, span, ds, d_start, d_end, sig_m1;
   logic signed [47:0] qm;
   logic signed [48:0] t_m_qm, p_two, p_one;
   logic signed [NUM_W-1:0] n_slope, n_sig, n_d, n_t, n_r, n_u0, n_un;

   assign dy      = 33'(yc_ff) - 33'(yb_ff);
   assign dx_cb   = 33'(xc_ff) - 33'(xb_ff);
   assign dx_ba   = 33'(xb_ff) - 33'(xa_ff);
   assign span    = 33'(xc_ff) - 33'(xa_ff);
   assign ds      = 33'(sr_ff) - 33'(sl_ff);
   assign d_start = 33'(sr_ff) - 33'(start_slope_ff);
   assign d_end   = 33'(end_slope_ff) - 33'(sr_ff);
   assign sig_m1  = 33'(sig_ff) - 33'(ONE_Q);
   assign qm      = qmul(prod_ff);
   assign t_m_qm  = 49'(t_ff) - 49'(qm);
   assign p_two   = 49'(qm) + 49'(TWO_Q);
   assign p_one   = 49'(qm) + 49'(ONE_Q);

   assign n_slope = NUM_W'(dy) <<< FRAC_W;
   assign n_sig   = NUM_W'(dx_ba) <<< FRAC_W;
   assign n_d     = NUM_W'(sig_m1) <<< FRAC_W;
   assign n_t     = (NUM_W'(ds) * NUM_W'(6)) <<< FRAC_W;
   assign n_r     = NUM_W'(t_m_qm) <<< FRAC_W;
   assign n_u0    = (NUM_W'(d_start) * NUM_W'(3)) <<< FRAC_W;
   assign n_un    = (NUM_W'(d_end) * NUM_W'(3)) <<< FRAC_W;

   csd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      order_err_in   = order_err_ff;
      issued_in      = issued_ff;
      rsp_valid_in   = rsp_valid_ff;
      natural_in     = natural_ff;
      start_slope_in = start_slope_ff;
      end_slope_in   = end_slope_ff;
      last_x_in      = last_x_ff;
      n_in           = n_ff;
      idx_in         = idx_ff;
      xa_in = xa_ff;  xb_in = xb_ff;  xc_in = xc_ff;
      yb_in = yb_ff;  yc_in = yc_ff;
      sl_in = sl_ff;  sr_in = sr_ff;  sig_in = sig_ff;
      d_in  = d_ff;   r_in  = r_ff;   t_in   = t_ff;
      p_in    = p_ff;
      prod_in = prod_ff;
      rsp_in  = rsp_ff;
      pt_we    = 1'b0;
      pt_raddr = idx_ff + IDX_W'(1);
      co_we    = 1'b0;
      co_wdata = '{d: d_ff, r: r_ff};
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      cnt_new   = count_ff;
      err_new   = order_err_ff;

      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            CSR_NATURAL: natural_in     = csr_pwdata[0];
            CSR_START:   start_slope_in = csr_pwdata;
            CSR_END:     end_slope_in   = csr_pwdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < CNT_MAX) begin
                  pt_we = 1'b1;
                  if (count_ff != '0 && req_data.x_value <= last_x_ff) begin
                     err_new = 1'b1;
                  end
                  last_x_in = req_data.x_value;
                  cnt_new   = count_ff + CNT_W'(1);
               end
               if (req_data.last_point) begin
                  count_in     = '0;
                  order_err_in = 1'b0;
                  n_in         = cnt_new;
                  idx_in       = '0;
                  if (cnt_new < CNT_W'(2) || err_new) begin
                     rsp_in       = '{second_deriv: '0, point_index: '0,
                                      last_result: 1'b1, error_flag: 1'b1};
                     rsp_valid_in = 1'b1;
                     state_in     = ST_OHOLD;
                  end else begin
                     state_in = ST_FETCH0;
                  end
               end else begin
                  count_in     = cnt_new;
                  order_err_in = err_new;
               end
            end
         end
         ST_FETCH0: begin
            pt_raddr = '0;
            state_in = ST_CAP0;
         end
         ST_CAP0: begin
            xc_in    = pt_rd_ff.x;
            yc_in    = pt_rd_ff.y;
            state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_CAP;
         ST_CAP: begin
            xa_in    = xb_ff;
            xb_in    = xc_ff;
            xc_in    = pt_rd_ff.x;
            yb_in    = yc_ff;
            yc_in    = pt_rd_ff.y;
            sl_in    = sr_ff;
            state_in = ST_SLOPE;
         end
         ST_SLOPE: begin
            div_num = n_slope;
            div_den = DEN_W'(dx_cb);
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               sr_in     = div_quot;
               state_in  = (idx_ff == '0) ? ST_FIRST : ST_SIG;
            end
         end
         ST_FIRST: begin
            if (natural_ff) begin
               d_in     = '0;
               r_in     = '0;
               state_in = ST_WR;
            end else begin
               div_num = n_u0;
               div_den = DEN_W'(dx_cb);
               if (!issued_ff) begin
                  div_start = 1'b1;
                  issued_in = 1'b1;
               end else if (div_done) begin
                  issued_in = 1'b0;
                  d_in      = NEG_HALF_Q;
                  r_in      = div_quot;
                  state_in  = ST_WR;
               end
            end
         end
         ST_WR: begin
            co_we  = 1'b1;
            idx_in = idx_ff + IDX_W'(1);
            if (CNT_W'(idx_ff) + CNT_W'(2) < n_ff) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_SIG: begin
            div_num = n_sig;
            div_den = DEN_W'(span);
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               sig_in    = div_quot;
               state_in  = ST_MULP;
            end
         end
         ST_MULP: begin
            prod_in  = sig_ff * d_ff;
            state_in = ST_P;
         end
         ST_P: begin
            p_in     = (p_two < 49'sd1) ? DEN_W'(1) : DEN_W'(p_two);
            state_in = ST_D;
         end
         ST_D: begin
            div_num = n_d;
            div_den = p_ff;
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               d_in      = div_quot;
               state_in  = ST_T;
            end
         end
         ST_T: begin
            div_num = n_t;
            div_den = DEN_W'(span);
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               t_in      = div_quot;
               state_in  = ST_MULR;
            end
         end
         ST_MULR: begin
            prod_in  = sig_ff * r_ff;
            state_in = ST_R;
         end
         ST_R: begin
            div_num = n_r;
            div_den = p_ff;
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               r_in      = div_quot;
               state_in  = ST_WR;
            end
         end
         ST_LAST: begin
            if (natural_ff) begin
               d_in     = '0;
               state_in = ST_WRN;
            end else begin
               div_num = n_un;
               div_den = DEN_W'(dx_cb);
               if (!issued_ff) begin
                  div_start = 1'b1;
                  issued_in = 1'b1;
               end else if (div_done) begin
                  issued_in = 1'b0;
                  t_in      = div_quot;
                  state_in  = ST_MULQ1;
               end
            end
         end
         ST_MULQ1: begin
            prod_in  = HALF_Q * d_ff;
            state_in = ST_QP;
         end
         ST_QP: begin
            p_in     = (p_one < 49'sd1) ? DEN_W'(1) : DEN_W'(p_one);
            state_in = ST_MULQ2;
         end
         ST_MULQ2: begin
            prod_in  = HALF_Q * r_ff;
            state_in = ST_DN;
         end
         ST_DN: begin
            div_num = n_r;
            div_den = p_ff;
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               d_in      = div_quot;
               state_in  = ST_WRN;
            end
         end
         ST_WRN: begin
            co_we    = 1'b1;
            idx_in   = idx_ff - IDX_W'(1);
            state_in = ST_BFETCH;
         end
         ST_BFETCH: state_in = ST_BMUL;
         ST_BMUL: begin
            prod_in  = co_rd_ff.d * d_ff;
            r_in     = co_rd_ff.r;
            state_in = ST_BSUM;
         end
         ST_BSUM: begin
            d_in     = sat32(64'(qm) + 64'(r_ff));
            co_we    = 1'b1;
            co_wdata = '{d: sat32(64'(qm) + 64'(r_ff)), r: r_ff};
            if (idx_ff == '0) begin
               state_in = ST_OFETCH;
            end else begin
               idx_in   = idx_ff - IDX_W'(1);
               state_in = ST_BFETCH;
            end
         end
         ST_OFETCH: state_in = ST_OCAP;
         ST_OCAP: begin
            rsp_in = '{second_deriv: co_rd_ff.d,
                       point_index:  PIDX_W'(idx_ff),
                       last_result:  (CNT_W'(idx_ff) + CNT_W'(1) == n_ff),
                       error_flag:   1'b0};
            rsp_valid_in = 1'b1;
            state_in     = ST_OHOLD;
         end
         ST_OHOLD: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.last_result) begin
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_OFETCH;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         count_ff       <= '0;
         order_err_ff   <= 1'b0;
         issued_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         natural_ff     <= 1'b1;
         start_slope_ff <= '0;
         end_slope_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         order_err_ff   <= order_err_in;
         issued_ff      <= issued_in;
         rsp_valid_ff   <= rsp_valid_in;
         natural_ff     <= natural_in;
         start_slope_ff <= start_slope_in;
         end_slope_ff   <= end_slope_in;
      end
   end

   always_ff @(posedge clock) begin
      last_x_ff <= last_x_in;
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      xa_ff <= xa_in;  xb_ff <= xb_in;  xc_ff <= xc_in;
      yb_ff <= yb_in;  yc_ff <= yc_in;
      sl_ff <= sl_in;  sr_ff <= sr_in;  sig_ff <= sig_in;
      d_ff  <= d_in;   r_ff  <= r_in;   t_ff   <= t_in;
      p_ff    <= p_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[count_ff[IDX_W-1:0]] <= '{x: req_data.x_value, y: req_data.y_value};
      end
      pt_rd_ff <= pt_mem[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (co_we) begin
         co_mem[idx_ff] <= co_wdata;
      end
      co_rd_ff <= co_mem[idx_ff];
   end

   always_comb begin
      case (csr_paddr)
         CSR_NATURAL: csr_prdata = {{(DATA_W-1){1'b0}}, natural_ff};
         CSR_START:   csr_prdata = start_slope_ff;
         CSR_END:     csr_prdata = end_slope_ff;
         default:     csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_ready  = (state_ff == ST_LOAD);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_ready_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("req_ready while a result beat is pending");

   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_result) |=> req_ready)
      else $error("load not reopened after last result beat");

   a_div_issued: assert property (@(posedge clock) disable iff (reset)
      div_done |-> issued_ff)
      else $error("divider finished without an issued division");
`endif

endmodule
